>>> hw/rtl/nrmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA RMC timestamp package
// Shared word types, character codes and small helper functions for the
// RMC sentence parser, the timestamp conversion pipeline and the top level.
// ----------------------------------------------------------------------------
package nrmc_pkg;

    // Input word: one sentence byte and the last-byte flag.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_sentence;
    } t_in_word;

    // Result word delivered once per sentence.
    typedef struct packed {
        logic [31:0] next_second;
        logic        from_fix;
        logic        sentence_is_rmc;
        logic [31:0] fix_update_count;
        logic [31:0] holdover_count;
    } t_out_word;

    // Sentence summary handed from the parser to the conversion pipeline.
    // The digit fields are right-aligned BCD, six digits each.
    typedef struct packed {
        logic        is_rmc;
        logic        date_seen;
        logic [23:0] time_bcd;
        logic [23:0] date_bcd;
    } t_snap;

    // Converted timestamp handed from the pipeline to the holdover stage.
    typedef struct packed {
        logic        is_rmc;
        logic        fix;
        logic [31:0] stamp;
    } t_stamp;

    // Character codes used by the parser.
    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_NINE   = 8'h39;
    localparam logic [7:0] C_UPPER_A = 8'h41;
    localparam logic [7:0] C_UPPER_C = 8'h43;
    localparam logic [7:0] C_UPPER_M = 8'h4D;
    localparam logic [7:0] C_UPPER_R = 8'h52;

    // The date field follows this comma, counted from byte one.
    localparam logic [3:0] DATE_COMMA = 4'd9;

    // Day of year at the start of each month, non-leap year.
    function automatic logic [8:0] month_start(input logic [3:0] month);
        logic [8:0] days;
        unique case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    // Two BCD digits to binary, 0 to 99.
    function automatic logic [6:0] bcd2_to_bin(input logic [7:0] bcd);
        logic [6:0] tens;
        tens = {3'd0, bcd[7:4]};
        return 7'((tens << 3) + (tens << 1) + {3'd0, bcd[3:0]});
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/nrmc_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA RMC byte parser
// Follows the sentence one accepted byte per cycle, gathers the time and date
// digits and hands a summary to the conversion pipeline on the last byte.
// ----------------------------------------------------------------------------
module nrmc_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire nrmc_pkg::t_in_word i_word,
    output logic                   o_snap_valid,
    output nrmc_pkg::t_snap        o_snap
);
    import nrmc_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TIME,
        PH_FRAC,
        PH_STATUS,
        PH_SKIP,
        PH_DATE,
        PH_DATE_DONE,
        PH_FAIL
    } t_phase;

    // Byte position saturates at seven; only positions zero to six matter.
    logic [2:0]  r_pos,      n_pos;
    logic [3:0]  r_commas,   n_commas;
    t_phase      r_phase,    n_phase;
    logic [23:0] r_time_bcd, n_time_bcd;
    logic [23:0] r_date_bcd, n_date_bcd;
    logic [2:0]  r_count,    n_count;
    logic        r_name_bad, n_name_bad;
    logic        r_nul,      n_nul;

    logic [7:0]  rx;
    logic        is_digit;
    logic [2:0]  count_inc;

    assign rx        = i_word.rx_byte;
    assign is_digit  = (rx >= C_ZERO) && (rx <= C_NINE);
    assign count_inc = (r_count == 3'd7) ? 3'd7 : r_count + 3'd1;

    // Next-state logic for one accepted byte.
    always_comb begin
        n_pos      = r_pos;
        n_commas   = r_commas;
        n_phase    = r_phase;
        n_time_bcd = r_time_bcd;
        n_date_bcd = r_date_bcd;
        n_count    = r_count;
        n_name_bad = r_name_bad;
        n_nul      = r_nul;
        if (i_accept) begin
            // The sentence name is checked even after a NUL byte.
            if ((r_pos == 3'd3 && rx != C_UPPER_R) ||
                (r_pos == 3'd4 && rx != C_UPPER_M) ||
                (r_pos == 3'd5 && rx != C_UPPER_C)) begin
                n_name_bad = 1'b1;
            end
            if (!r_nul) begin
                if (rx == C_NUL) begin
                    n_nul = 1'b1;
                end else begin
                    if (r_pos != 3'd0 && rx == C_COMMA && r_commas != 4'hF) begin
                        n_commas = r_commas + 4'd1;
                    end
                    unique case (r_phase)
                        PH_HEADER: begin
                            if ((r_pos == 3'd0 && rx != C_DOLLAR) ||
                                (r_pos == 3'd3 && rx != C_UPPER_R) ||
                                (r_pos == 3'd4 && rx != C_UPPER_M) ||
                                (r_pos == 3'd5 && rx != C_UPPER_C) ||
                                (r_pos == 3'd6 && rx != C_COMMA)) begin
                                n_phase = PH_FAIL;
                            end else if (r_pos == 3'd6) begin
                                n_phase = PH_TIME;
                                n_count = 3'd0;
                            end
                        end
                        PH_TIME: begin
                            if (is_digit) begin
                                if (r_count >= 3'd6) begin
                                    n_phase = PH_FAIL;
                                end else begin
                                    n_time_bcd = {r_time_bcd[19:0], rx[3:0]};
                                    n_count    = count_inc;
                                end
                            end else if (rx == C_DOT && r_count != 3'd0) begin
                                n_phase = PH_FRAC;
                                n_count = 3'd0;
                            end else begin
                                n_phase = PH_FAIL;
                            end
                        end
                        PH_FRAC: begin
                            if (is_digit) begin
                                n_count = count_inc;
                            end else if (rx == C_COMMA && r_count != 3'd0) begin
                                n_phase = PH_STATUS;
                            end else begin
                                n_phase = PH_FAIL;
                            end
                        end
                        PH_STATUS: begin
                            n_phase = (rx == C_UPPER_A) ? PH_SKIP : PH_FAIL;
                        end
                        PH_SKIP: begin
                            if (rx == C_COMMA && n_commas == DATE_COMMA) begin
                                n_phase = PH_DATE;
                                n_count = 3'd0;
                            end
                        end
                        PH_DATE: begin
                            if (is_digit) begin
                                if (r_count >= 3'd6) begin
                                    n_phase = PH_FAIL;
                                end else begin
                                    n_date_bcd = {r_date_bcd[19:0], rx[3:0]};
                                    n_count    = count_inc;
                                end
                            end else begin
                                n_phase = (r_count != 3'd0) ? PH_DATE_DONE : PH_FAIL;
                            end
                        end
                        PH_DATE_DONE: begin
                            n_phase = r_phase;
                        end
                        PH_FAIL: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
            if (r_pos != 3'd7) begin
                n_pos = r_pos + 3'd1;
            end
        end
    end

    // Sentence summary, taken from the state after the last byte.
    always_comb begin
        o_snap_valid     = i_accept && i_word.end_of_sentence;
        o_snap.is_rmc    = !n_name_bad && (n_pos >= 3'd6);
        o_snap.date_seen = (n_phase == PH_DATE_DONE) ||
                           (n_phase == PH_DATE && n_count != 3'd0);
        o_snap.time_bcd  = n_time_bcd;
        o_snap.date_bcd  = n_date_bcd;
    end

    // Per-sentence state; it returns to its reset value after the last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_word.end_of_sentence)) begin
            r_pos      <= 3'd0;
            r_commas   <= 4'd0;
            r_phase    <= PH_HEADER;
            r_time_bcd <= 24'd0;
            r_date_bcd <= 24'd0;
            r_count    <= 3'd0;
            r_name_bad <= 1'b0;
            r_nul      <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_commas   <= n_commas;
            r_phase    <= n_phase;
            r_time_bcd <= n_time_bcd;
            r_date_bcd <= n_date_bcd;
            r_count    <= n_count;
            r_name_bad <= n_name_bad;
            r_nul      <= n_nul;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/nrmc_convert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA RMC timestamp conversion pipeline
// Four registered stages turn the BCD time and date of a sentence into Unix
// seconds: field decode, day and second-of-day sums, and the final multiply.
// ----------------------------------------------------------------------------
module nrmc_convert (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_snap_valid,
    input  wire nrmc_pkg::t_snap  i_snap,
    output logic                  o_snap_ready,
    output logic                  o_stamp_valid,
    output nrmc_pkg::t_stamp      o_stamp,
    input  wire logic             i_stamp_ready
);
    import nrmc_pkg::*;

    typedef struct packed {
        logic       is_rmc;
        logic       fix;
        logic [6:0] year;
        logic [6:0] mday;
        logic [6:0] hour;
        logic [6:0] mnt;
        logic [6:0] sec;
        logic [8:0] mstart;
        logic       leap;
    } t_fields;

    typedef struct packed {
        logic        is_rmc;
        logic        fix;
        logic [15:0] days;
        logic [18:0] sod;
    } t_days;

    logic    r_v1, r_v2, r_v3, r_v4;
    t_snap   r_s1;
    t_fields r_s2, n_s2;
    t_days   r_s3, n_s3;
    t_stamp  r_s4, n_s4;
    logic    rdy1, rdy2, rdy3, rdy4;

    // A stage takes a new word when it is empty or its word moves on.
    assign rdy4 = !r_v4 || i_stamp_ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_snap_ready  = rdy1;
    assign o_stamp_valid = r_v4;
    assign o_stamp       = r_s4;

    // Stage one: decode the BCD pairs and check the month.
    always_comb begin
        logic [6:0] mon;
        mon         = bcd2_to_bin(r_s1.date_bcd[15:8]);
        n_s2.is_rmc = r_s1.is_rmc;
        n_s2.fix    = r_s1.is_rmc && r_s1.date_seen && (mon >= 7'd1) && (mon <= 7'd12);
        n_s2.year   = bcd2_to_bin(r_s1.date_bcd[7:0]);
        n_s2.mday   = bcd2_to_bin(r_s1.date_bcd[23:16]);
        n_s2.hour   = bcd2_to_bin(r_s1.time_bcd[23:16]);
        n_s2.mnt    = bcd2_to_bin(r_s1.time_bcd[15:8]);
        n_s2.sec    = bcd2_to_bin(r_s1.time_bcd[7:0]);
        n_s2.mstart = month_start(mon[3:0]);
        n_s2.leap   = (mon > 7'd2) && (n_s2.year[1:0] == 2'd0);
    end

    // Stage two: days since 1970 and seconds of the day.
    always_comb begin
        logic [15:0] year16;
        year16      = {9'd0, r_s2.year};
        n_s3.is_rmc = r_s2.is_rmc;
        n_s3.fix    = r_s2.fix;
        n_s3.days   = (year16 + 16'd30) * 16'd365 + ((year16 + 16'd31) >> 2)
                    + {7'd0, r_s2.mstart} + {15'd0, r_s2.leap}
                    + {9'd0, r_s2.mday} - 16'd1;
        n_s3.sod    = {12'd0, r_s2.hour} * 19'd3600 + {12'd0, r_s2.mnt} * 19'd60
                    + {12'd0, r_s2.sec};
    end

    // Stage three: scale days to seconds, modulo two to the 32.
    always_comb begin
        n_s4.is_rmc = r_s3.is_rmc;
        n_s4.fix    = r_s3.fix;
        n_s4.stamp  = {16'd0, r_s3.days} * 32'd86400 + {13'd0, r_s3.sod};
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_snap_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (rdy1) r_s1 <= i_snap;
        if (rdy2) r_s2 <= n_s2;
        if (rdy3) r_s3 <= n_s3;
        if (rdy4) r_s4 <= n_s4;
    end

endmodule
`default_nettype wire

>>> hw/rtl/nmea_rmc_timestamp_holdover_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NMEA RMC timestamp core with holdover
// Parses RMC sentences byte by byte and, at each sentence end, delivers the
// Unix second to load for the next pulse, either from the fix or by holdover.
//
//   Channel  Direction  Handshake                    Word
//   input    in         i_in_valid / o_in_stall      t_in_word, one byte
//   output   out        o_out_valid / i_out_stall    t_out_word, one per sentence
//
// One byte is taken every cycle unless the input stalls. After its last byte
// is taken, a sentence passes through the four conversion stage registers and
// the holdover output register before its result appears.
// Reset is synchronous and clears the parser, the pipeline valid bits, the
// held timestamp, both counters and the output valid bit.
// A stalled output holds its word; the four pipeline stages keep filling, and
// the input stalls only when all of them hold results.
// ----------------------------------------------------------------------------
module nmea_rmc_timestamp_holdover_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire nrmc_pkg::t_in_word  i_in_word,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output nrmc_pkg::t_out_word      o_out_word,
    input  wire logic                i_out_stall
);
    import nrmc_pkg::*;

    logic        in_accept;
    logic        snap_valid;
    t_snap       snap;
    logic        snap_ready;
    logic        stamp_valid;
    t_stamp      stamp;
    logic        out_ready;
    logic        stamp_load;

    logic [31:0] r_held,       n_held;
    logic [31:0] r_fix_count,  n_fix_count;
    logic [31:0] r_hold_count, n_hold_count;
    logic        r_out_valid;
    t_out_word   r_out_word,   n_out_word;

    assign o_in_stall = !snap_ready;
    assign in_accept  = i_in_valid && snap_ready;

    nrmc_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_word       (i_in_word),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    nrmc_convert u_convert (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_snap_valid  (snap_valid),
        .i_snap        (snap),
        .o_snap_ready  (snap_ready),
        .o_stamp_valid (stamp_valid),
        .o_stamp       (stamp),
        .i_stamp_ready (out_ready)
    );

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign stamp_load = stamp_valid && out_ready;

    // Holdover: for RMC, a valid fix loads the held second, else it adds one.
    always_comb begin
        n_held       = r_held;
        n_fix_count  = r_fix_count;
        n_hold_count = r_hold_count;
        if (stamp.is_rmc) begin
            if (stamp.fix) begin
                n_held      = stamp.stamp;
                n_fix_count = r_fix_count + 32'd1;
            end else begin
                n_held       = r_held + 32'd1;
                n_hold_count = r_hold_count + 32'd1;
            end
        end
        n_out_word.next_second      = stamp.is_rmc ? n_held + 32'd1 : 32'd0;
        n_out_word.from_fix         = stamp.is_rmc && stamp.fix;
        n_out_word.sentence_is_rmc  = stamp.is_rmc;
        n_out_word.fix_update_count = n_fix_count;
        n_out_word.holdover_count   = n_hold_count;
    end

    // Timestamp state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= 32'd0;
            r_fix_count  <= 32'd0;
            r_hold_count <= 32'd0;
            r_out_valid  <= 1'b0;
        end else if (stamp_load) begin
            r_held       <= n_held;
            r_fix_count  <= n_fix_count;
            r_hold_count <= n_hold_count;
            r_out_valid  <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stamp_load) r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A word from a fix must come from an RMC sentence.
    a_fix_is_rmc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.from_fix) |-> o_out_word.sentence_is_rmc)
        else $error("fix reported on a sentence that is not RMC");

    // A sentence that is not RMC leaves a zero timestamp and no fix.
    a_not_rmc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.sentence_is_rmc)
        |-> (o_out_word.next_second == 32'd0 && !o_out_word.from_fix))
        else $error("non-RMC result carries a timestamp");

    // Only one of the two counters moves for a sentence.
    a_one_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_fix_count)) |-> $stable(r_hold_count))
        else $error("fix and holdover counters moved together");

    // Holdover advances the held second by exactly one.
    a_holdover_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stamp_load && stamp.is_rmc && !stamp.fix)
        |=> (r_held == $past(r_held) + 32'd1))
        else $error("holdover did not advance the held second by one");

endmodule
`default_nettype wire

>>> tb/nmea_rmc_timestamp_holdover_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC timestamp core testbench
// Sends a short set of hand-built sentences, then random RMC sentences with
// random content, some broken on purpose, plus noise and foreign sentences.
// A predictor inside the bench tracks the parser, the held timestamp and both
// counters, and every result word is checked field by field in order. Both
// sides idle at random, and once the receiver holds off long enough for the
// core to fill up and stall its input.
// ----------------------------------------------------------------------------
module nmea_rmc_timestamp_holdover_core_test;
    import nrmc_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int HOLD_OFF_AFTER  = 8;
    localparam int RANDOM_BYTES    = 1150;
    localparam int MIN_SENTENCES   = 20;
    localparam int LONG_AT         = 10;
    localparam int LONG_LENGTH     = 300;
    localparam int MAX_REPORTS     = 10;

    // Parser phases of the predictor.
    typedef enum logic [3:0] {
        PH_HEADER,
        PH_TIME,
        PH_FRAC,
        PH_STATUS,
        PH_SKIP,
        PH_DATE,
        PH_DATE_DONE,
        PH_FAIL
    } rmc_phase_e;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;
    logic      out_stall = 1'b0;

    // Stimulus and expected results.
    t_in_word   pending_bytes[$];
    logic [7:0] sentence[$];
    t_out_word  expected_stamps[$];

    // Predictor state for the sentence being parsed.
    logic [7:0]  cur_pos      = '0;
    logic [3:0]  cur_commas   = '0;
    rmc_phase_e  cur_phase    = PH_HEADER;
    logic [31:0] time_acc     = '0;
    logic [31:0] date_acc     = '0;
    logic [2:0]  digit_run    = '0;
    logic        name_bad     = 1'b0;
    logic        nul_seen     = 1'b0;

    // Predictor state kept across sentences.
    logic [31:0] held_stamp     = '0;
    logic [31:0] fix_total      = '0;
    logic [31:0] holdover_total = '0;

    // Handshake pacing.
    int   send_wait    = 0;
    int   recv_wait    = 0;
    logic send_burst   = 1'b0;
    logic recv_burst   = 1'b0;
    int   hold_left    = 0;
    logic holding_off  = 1'b0;
    logic hold_done    = 1'b0;
    int   results_seen = 0;
    int   mismatches   = 0;
    int   cycle_count  = 0;

    nmea_rmc_timestamp_holdover_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle cycles before the next word; none while a burst stretch is on.
    function automatic int idle_draw(input logic burst);
        return burst ? 0 : int'($urandom_range(0, 4));
    endfunction

    // Converts hhmmss and ddmmyy digits to Unix seconds, 32-bit wrapping.
    function automatic logic fix_to_unix(input logic [31:0] t, input logic [31:0] d,
                                         output logic [31:0] stamp);
        logic [31:0] sec, mnt, hour, year, mon, mday, yday, days;
        sec   = t % 100;
        mnt   = (t / 100) % 100;
        hour  = t / 10000;
        year  = 2000 + d % 100;
        mon   = (d / 100) % 100;
        mday  = d / 10000;
        stamp = '0;
        if (mon < 1 || mon > 12) begin
            return 1'b0;
        end
        case (mon)
            1:       yday = 0;
            2:       yday = 31;
            3:       yday = 59;
            4:       yday = 90;
            5:       yday = 120;
            6:       yday = 151;
            7:       yday = 181;
            8:       yday = 212;
            9:       yday = 243;
            10:      yday = 273;
            11:      yday = 304;
            default: yday = 334;
        endcase
        days = (year - 1970) * 365 + (year - 1969) / 4 + yday;
        if (mon > 2 && year % 4 == 0) begin
            days = days + 1;
        end
        stamp = days * 86400 + mday * 86400 - 86400 + hour * 3600 + mnt * 60 + sec;
        return 1'b1;
    endfunction

    // Advances the predictor by one accepted word and queues the result at
    // the end of a sentence.
    task automatic rmc_step(input t_in_word w);
        logic [7:0]  b;
        logic        is_digit;
        logic        got_fix;
        logic [31:0] stamp;
        t_out_word   want;
        b        = w.rx_byte;
        is_digit = (b >= C_ZERO && b <= C_NINE);

        // Name bytes are compared even after a NUL.
        if ((cur_pos == 3 && b != C_UPPER_R) || (cur_pos == 4 && b != C_UPPER_M) ||
            (cur_pos == 5 && b != C_UPPER_C)) begin
            name_bad = 1'b1;
        end

        // Field parsing stops for good at the first NUL.
        if (!nul_seen) begin
            if (b == C_NUL) begin
                nul_seen = 1'b1;
            end else begin
                if (cur_pos >= 1 && b == C_COMMA && cur_commas != 4'd15) begin
                    cur_commas = cur_commas + 1;
                end
                case (cur_phase)
                    PH_HEADER: begin
                        if ((cur_pos == 0 && b != C_DOLLAR) ||
                            (cur_pos == 3 && b != C_UPPER_R) ||
                            (cur_pos == 4 && b != C_UPPER_M) ||
                            (cur_pos == 5 && b != C_UPPER_C) ||
                            (cur_pos == 6 && b != C_COMMA)) begin
                            cur_phase = PH_FAIL;
                        end else if (cur_pos == 6) begin
                            cur_phase = PH_TIME;
                            digit_run = '0;
                        end
                    end
                    PH_TIME: begin
                        if (is_digit) begin
                            if (digit_run >= 6) begin
                                cur_phase = PH_FAIL;
                            end else begin
                                time_acc  = time_acc * 10 + (b - C_ZERO);
                                digit_run = digit_run + 1;
                            end
                        end else if (b == C_DOT && digit_run >= 1) begin
                            cur_phase = PH_FRAC;
                            digit_run = '0;
                        end else begin
                            cur_phase = PH_FAIL;
                        end
                    end
                    PH_FRAC: begin
                        if (is_digit) begin
                            if (digit_run != 3'd7) begin
                                digit_run = digit_run + 1;
                            end
                        end else if (b == C_COMMA && digit_run >= 1) begin
                            cur_phase = PH_STATUS;
                        end else begin
                            cur_phase = PH_FAIL;
                        end
                    end
                    PH_STATUS: begin
                        cur_phase = (b == C_UPPER_A) ? PH_SKIP : PH_FAIL;
                    end
                    PH_SKIP: begin
                        if (b == C_COMMA && cur_commas == DATE_COMMA) begin
                            cur_phase = PH_DATE;
                            digit_run = '0;
                        end
                    end
                    PH_DATE: begin
                        if (is_digit) begin
                            if (digit_run >= 6) begin
                                cur_phase = PH_FAIL;
                            end else begin
                                date_acc  = date_acc * 10 + (b - C_ZERO);
                                digit_run = digit_run + 1;
                            end
                        end else begin
                            cur_phase = (digit_run >= 1) ? PH_DATE_DONE : PH_FAIL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (cur_pos != 8'd255) begin
            cur_pos = cur_pos + 1;
        end
        if (!w.end_of_sentence) begin
            return;
        end

        // End of sentence: fix, holdover or a foreign sentence.
        want = '0;
        if (!name_bad && cur_pos >= 6) begin
            got_fix = 1'b0;
            if (cur_phase == PH_DATE_DONE || (cur_phase == PH_DATE && digit_run >= 1)) begin
                got_fix = fix_to_unix(time_acc, date_acc, stamp);
            end
            if (got_fix) begin
                fix_total  = fix_total + 1;
                held_stamp = stamp;
            end else begin
                held_stamp     = held_stamp + 1;
                holdover_total = holdover_total + 1;
            end
            want.next_second     = held_stamp + 1;
            want.from_fix        = got_fix;
            want.sentence_is_rmc = 1'b1;
        end
        want.fix_update_count = fix_total;
        want.holdover_count   = holdover_total;
        expected_stamps.push_back(want);

        cur_pos    = '0;
        cur_commas = '0;
        cur_phase  = PH_HEADER;
        time_acc   = '0;
        date_acc   = '0;
        digit_run  = '0;
        name_bad   = 1'b0;
        nul_seen   = 1'b0;
    endtask

    // Compares one result word with the oldest expectation.
    task automatic check_result(input t_out_word got);
        t_out_word want;
        if (expected_stamps.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("unexpected result word: next_second=%0d fix=%0b rmc=%0b",
                         got.next_second, got.from_fix, got.sentence_is_rmc);
            end
            return;
        end
        want = expected_stamps.pop_front();
        if (got.next_second != want.next_second || got.from_fix != want.from_fix ||
            got.sentence_is_rmc != want.sentence_is_rmc ||
            got.fix_update_count != want.fix_update_count ||
            got.holdover_count != want.holdover_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("result %0d mismatch at %0t", results_seen, $realtime);
                $display("  expected: next_second=%0d fix=%0b rmc=%0b fixes=%0d holdovers=%0d",
                         want.next_second, want.from_fix, want.sentence_is_rmc,
                         want.fix_update_count, want.holdover_count);
                $display("  actual:   next_second=%0d fix=%0b rmc=%0b fixes=%0d holdovers=%0d",
                         got.next_second, got.from_fix, got.sentence_is_rmc,
                         got.fix_update_count, got.holdover_count);
            end
        end
    endtask

    // Sentence building helpers.
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            sentence.push_back(s[i]);
        end
    endtask

    task automatic add_digits(input int n);
        repeat (n) begin
            sentence.push_back(C_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    // Moves the sentence into the send queue, flagging its last byte.
    task automatic send_sentence();
        t_in_word w;
        for (int i = 0; i < sentence.size(); i++) begin
            w.rx_byte         = sentence[i];
            w.end_of_sentence = (i == sentence.size() - 1);
            pending_bytes.push_back(w);
        end
        sentence.delete();
    endtask

    // An RMC sentence with random content; status and date may be invalid.
    task automatic build_rmc();
        string field_chars;
        field_chars = "0123456789.NSEWM-";
        add_text($urandom_range(0, 1) ? "$GPRMC," : "$GNRMC,");
        if ($urandom_range(0, 3) != 0) begin
            add_text($sformatf("%02d%02d%02d", $urandom_range(0, 23),
                               $urandom_range(0, 59), $urandom_range(0, 59)));
        end else begin
            add_digits($urandom_range(1, 6));
        end
        add_text(".");
        add_digits($urandom_range(1, 3));
        add_text(($urandom_range(0, 9) != 0) ? ",A," : ",V,");
        // Six filler fields bring the comma count up to the date field.
        repeat (6) begin
            repeat ($urandom_range(0, 5)) begin
                sentence.push_back(field_chars[$urandom_range(0, field_chars.len() - 1)]);
            end
            add_text(",");
        end
        case ($urandom_range(0, 7))
            0: add_digits($urandom_range(1, 5));
            1: add_digits(7);
            2: add_text($sformatf("%02d%02d%02d", $urandom_range(0, 99),
                                  $urandom_range(0, 99), $urandom_range(0, 99)));
            default: add_text($sformatf("%02d%02d%02d", $urandom_range(1, 31),
                                        $urandom_range(1, 12), $urandom_range(0, 99)));
        endcase
        case ($urandom_range(0, 2))
            0: add_text($sformatf(",,A*%02X", $urandom_range(0, 255)));
            1: repeat ($urandom_range(1, 10)) add_text(",");
            default: begin
            end
        endcase
    endtask

    // Fills the send queue, then releases reset and waits for the end.
    initial begin : stimulus
        int random_sentences;
        int directed_bytes;
        int idx;
        int cut;
        random_sentences = 0;

        // Directed sentences: epoch of the date range, extremes, bad status,
        // foreign and short sentences, a seventh date digit, a NUL, a bad
        // month, a high byte in a skipped field and an empty date.
        add_text("$GPRMC,000000.0,A,,,,,,,010100");
        send_sentence();
        add_text("$GNRMC,995959.99,A,,,,,,,991299,*");
        send_sentence();
        add_text("$GPRMC,235959.9,V,,,,,,,311299");
        send_sentence();
        add_text("$GPGGA,1");
        send_sentence();
        add_text("$GP");
        send_sentence();
        add_text("$GPRMC,1.1,A,,,,,,,1130001");
        send_sentence();
        add_text("$GPRMC,1.1,A,,,,,,,");
        sentence.push_back(C_NUL);
        add_text("010100");
        send_sentence();
        add_text("$GPRMC,120000.5,A,,,,,,,011300");
        send_sentence();
        add_text("$GPRMC,1.1,A,");
        sentence.push_back(8'hFF);
        add_text(",,,,,,010100");
        send_sentence();
        add_text("$GPRMC,1.1,A,,,,,,,,");
        send_sentence();
        directed_bytes = pending_bytes.size();

        // Random sentences, mostly well formed.
        while (pending_bytes.size() < directed_bytes + RANDOM_BYTES ||
               random_sentences < MIN_SENTENCES) begin
            if (random_sentences == LONG_AT) begin
                // One overlong sentence saturates the byte and comma counts.
                add_text("$GPRMC,");
                repeat (LONG_LENGTH) begin
                    sentence.push_back($urandom_range(0, 3) == 0 ? C_COMMA :
                                       8'($urandom_range(8'h20, 8'h7E)));
                end
            end else begin
                case ($urandom_range(0, 19))
                    0, 1: begin
                        // Noise of any byte values.
                        repeat ($urandom_range(1, 40)) begin
                            sentence.push_back(8'($urandom_range(0, 255)));
                        end
                    end
                    2: begin
                        // Shorter than the sentence name.
                        add_text("$GPRMC");
                        cut = $urandom_range(1, 5);
                        while (sentence.size() > cut) void'(sentence.pop_back());
                    end
                    3: begin
                        add_text("$GPGGA,");
                        add_digits($urandom_range(0, 20));
                    end
                    default: begin
                        build_rmc();
                        // A quarter of the RMC sentences get one defect.
                        if ($urandom_range(0, 3) == 0) begin
                            idx = $urandom_range(0, sentence.size() - 1);
                            case ($urandom_range(0, 5))
                                0: sentence[idx] = 8'($urandom_range(0, 255));
                                1: sentence.insert(idx, C_NUL);
                                2: begin
                                    cut = $urandom_range(1, sentence.size() - 1);
                                    while (sentence.size() > cut) void'(sentence.pop_back());
                                end
                                3: sentence[$urandom_range(3, 5)] = 8'($urandom_range(8'h41, 8'h5A));
                                4: sentence.insert(idx, C_ZERO + 8'($urandom_range(0, 9)));
                                default: if (sentence.size() > 1) sentence.delete(idx);
                            endcase
                        end
                    end
                endcase
            end
            send_sentence();
            random_sentences++;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
        while (expected_stamps.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_stamps.size() == 0) begin
            $display("nmea_rmc_timestamp_holdover_core_test: done, clean");
        end else begin
            $display("nmea_rmc_timestamp_holdover_core_test: done, errors");
        end
        $finish;
    end

    // Driver: offers queued words with random gaps and predicts each one
    // that the core takes.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                rmc_step(in_word);
            end
            if (!in_valid || !in_stall) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    in_valid  <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    if ($urandom_range(0, 39) == 0) begin
                        send_burst <= !send_burst;
                    end
                    in_word   <= pending_bytes.pop_front();
                    in_valid  <= 1'b1;
                    send_wait <= idle_draw(send_burst);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word and draws the stall before the next.
    always @(posedge clk) begin : monitor
        int wait_cycles;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                check_result(out_word);
                results_seen <= results_seen + 1;
                if ($urandom_range(0, 39) == 0) begin
                    recv_burst <= !recv_burst;
                end
                wait_cycles = idle_draw(recv_burst);
                recv_wait <= wait_cycles;
                out_stall <= (wait_cycles != 0) || holding_off;
            end else if (recv_wait != 0) begin
                recv_wait <= recv_wait - 1;
                out_stall <= (recv_wait != 1) || holding_off;
            end else begin
                out_stall <= holding_off;
            end
        end
    end

    // One long hold-off of the receiver so that the pipeline fills and the
    // input side stalls while words keep coming.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1) begin
                holding_off <= 1'b0;
            end
        end else if (!hold_done && results_seen == HOLD_OFF_AFTER) begin
            hold_left   <= HOLD_OFF_CYCLES;
            holding_off <= 1'b1;
            hold_done   <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("nmea_rmc_timestamp_holdover_core_test: done, errors");
            $finish;
        end
    end

endmodule
